[rtl/bdcf_pkg.sv]
// ---------------------------------------------------------------------------
// bdcf_pkg
// Types, constants and bit-shuffling functions shared by the dihedral
// canonical form block and its image generator.
// ---------------------------------------------------------------------------
package bdcf_pkg;

   localparam int unsigned BoardBits  = 64;
   localparam int unsigned RowBits    = 8;
   localparam int unsigned NumImages  = 8;
   localparam int unsigned ShiftBits  = 6;

   typedef logic [BoardBits-1:0]               word_type;
   typedef logic [ShiftBits-1:0]               shift_type;
   typedef logic [NumImages-1:0][BoardBits-1:0] image_set_type;
   typedef logic [NumImages-1:0][ShiftBits-1:0] shift_set_type;

   // Reverse the order of the eight rows.
   function automatic word_type flip_rows(input word_type b);
      word_type r;
      r = '0;
      for (int i = 0; i < 8; i++) begin
         r[8*(7-i) +: 8] = b[8*i +: 8];
      end
      return r;
   endfunction

   // Reverse the bit order inside each row.
   function automatic word_type flip_cols(input word_type b);
      word_type r;
      r = '0;
      for (int row = 0; row < 8; row++) begin
         for (int col = 0; col < 8; col++) begin
            r[row*8 + col] = b[row*8 + (7 - col)];
         end
      end
      return r;
   endfunction

   // Move the cell at (row, column) to (column, row).
   function automatic word_type transpose(input word_type b);
      word_type r;
      r = '0;
      for (int row = 0; row < 8; row++) begin
         for (int col = 0; col < 8; col++) begin
            r[col*8 + row] = b[row*8 + col];
         end
      end
      return r;
   endfunction

   // Index of the lowest set bit of an eight-bit vector; zero if none is set.
   function automatic logic [2:0] low_index(input logic [RowBits-1:0] v);
      logic [2:0] idx;
      idx = 3'd0;
      for (int i = 7; i >= 0; i--) begin
         if (v[i]) begin
            idx = 3'(i);
         end
      end
      return idx;
   endfunction

   // Total shift that normalises an image: eight per empty low row plus one
   // per empty low column.
   function automatic shift_type norm_shift(input word_type b);
      logic [RowBits-1:0] row_occ;
      logic [RowBits-1:0] col_occ;
      row_occ = '0;
      col_occ = '0;
      for (int row = 0; row < 8; row++) begin
         row_occ[row] = |b[row*8 +: 8];
         col_occ      = col_occ | b[row*8 +: 8];
      end
      return {low_index(row_occ), low_index(col_occ)};
   endfunction

endpackage

[rtl/bdcf_images.sv]
// ---------------------------------------------------------------------------
// bdcf_images
// Forms the eight dihedral images of a board and the shift that normalises
// each of them.
// ---------------------------------------------------------------------------
module bdcf_images (
   input  bdcf_pkg::word_type      board,
   output bdcf_pkg::image_set_type images,
   output bdcf_pkg::shift_set_type shifts,
   output logic                    empty
);

   bdcf_pkg::word_type fc;
   bdcf_pkg::word_type t;
   bdcf_pkg::word_type tfc;

   assign fc  = bdcf_pkg::flip_cols(board);
   assign t   = bdcf_pkg::transpose(board);
   assign tfc = bdcf_pkg::flip_cols(t);

   always_comb begin
      images[0] = board;
      images[1] = bdcf_pkg::flip_rows(board);
      images[2] = fc;
      images[3] = bdcf_pkg::flip_rows(fc);
      images[4] = t;
      images[5] = bdcf_pkg::flip_rows(t);
      images[6] = tfc;
      images[7] = bdcf_pkg::flip_rows(tfc);
      for (int i = 0; i < bdcf_pkg::NumImages; i++) begin
         shifts[i] = bdcf_pkg::norm_shift(images[i]);
      end
   end

   assign empty = (board == '0);

endmodule

[rtl/bitboard_dihedral_canonical_form.sv]
// ---------------------------------------------------------------------------
// bitboard_dihedral_canonical_form
// Canonical signature of an 8x8 bitboard under rotation, reflection and
// translation.
// ---------------------------------------------------------------------------
// Usage: the request channel (req_valid, req_stall, req_board) carries one
// board per word, row r in byte r and column c in bit c. The response
// channel (rsp_valid, rsp_stall, rsp_signature, rsp_empty_board) returns one
// word per board, in order. The signature is the smallest of the eight
// dihedral images after each has been slid down to its lowest occupied row
// and column. An empty board gives a zero signature with rsp_empty_board set.
// Throughput is one board per cycle while the receiver does not stall. A board
// accepted into the input register moves on through image and shift
// generation, the normalising barrel shifts, and a three-level registered
// minimum tree ending in the output register on the response port. Each stage carries
// a valid bit, and a stage loads whenever it is empty or the stage after it
// moves on, so bubbles close up. When the receiver stalls, the stages fill
// and req_stall rises once the input register is held; nothing is lost or
// repeated. Synchronous reset clears every valid bit; no data is needed.
// ---------------------------------------------------------------------------
module bitboard_dihedral_canonical_form (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_board,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_signature,
   output logic        rsp_empty_board
);

   // Stage one: input register.
   logic               v1_ff;
   bdcf_pkg::word_type board1_ff;

   // Stage two: images and their normalising shifts.
   logic                    v2_ff;
   logic                    empty2_ff;
   bdcf_pkg::image_set_type img2_ff;
   bdcf_pkg::shift_set_type sh2_ff;

   // Stage three: normalised images.
   logic                    v3_ff;
   logic                    empty3_ff;
   bdcf_pkg::image_set_type norm3_ff;

   // Stages four and five: minimum tree levels.
   logic                        v4_ff;
   logic                        empty4_ff;
   logic [3:0][63:0]            min4_ff;
   logic                        v5_ff;
   logic                        empty5_ff;
   logic [1:0][63:0]            min5_ff;

   // Stage six: output register.
   logic               v6_ff;
   logic               empty6_ff;
   bdcf_pkg::word_type sig6_ff;

   // Combinational results feeding the registers.
   bdcf_pkg::image_set_type img2_in;
   bdcf_pkg::shift_set_type sh2_in;
   logic                    empty2_in;
   bdcf_pkg::image_set_type norm3_in;
   logic [3:0][63:0]        min4_in;
   logic [1:0][63:0]        min5_in;
   bdcf_pkg::word_type      sig6_in;

   // A stage may load when it is empty or its contents move on this cycle.
   logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

   assign rdy6 = !v6_ff || !rsp_stall;
   assign rdy5 = !v5_ff || rdy6;
   assign rdy4 = !v4_ff || rdy5;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;

   assign req_stall = !rdy1;

   bdcf_images u_images (
      .board  (board1_ff),
      .images (img2_in),
      .shifts (sh2_in),
      .empty  (empty2_in)
   );

   always_comb begin
      for (int i = 0; i < bdcf_pkg::NumImages; i++) begin
         norm3_in[i] = img2_ff[i] >> sh2_ff[i];
      end
      for (int i = 0; i < 4; i++) begin
         min4_in[i] = (norm3_ff[2*i] < norm3_ff[2*i+1]) ? norm3_ff[2*i] : norm3_ff[2*i+1];
      end
      for (int i = 0; i < 2; i++) begin
         min5_in[i] = (min4_ff[2*i] < min4_ff[2*i+1]) ? min4_ff[2*i] : min4_ff[2*i+1];
      end
      // An empty board has no meaningful image, so its signature is forced to zero.
      if (empty5_ff) begin
         sig6_in = '0;
      end else begin
         sig6_in = (min5_ff[0] < min5_ff[1]) ? min5_ff[0] : min5_ff[1];
      end
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            v1_ff <= req_valid;
         end
         if (rdy2) begin
            v2_ff <= v1_ff;
         end
         if (rdy3) begin
            v3_ff <= v2_ff;
         end
         if (rdy4) begin
            v4_ff <= v3_ff;
         end
         if (rdy5) begin
            v5_ff <= v4_ff;
         end
         if (rdy6) begin
            v6_ff <= v5_ff;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (rdy1) begin
         board1_ff <= req_board;
      end
      if (rdy2) begin
         img2_ff   <= img2_in;
         sh2_ff    <= sh2_in;
         empty2_ff <= empty2_in;
      end
      if (rdy3) begin
         norm3_ff  <= norm3_in;
         empty3_ff <= empty2_ff;
      end
      if (rdy4) begin
         min4_ff   <= min4_in;
         empty4_ff <= empty3_ff;
      end
      if (rdy5) begin
         min5_ff   <= min5_in;
         empty5_ff <= empty4_ff;
      end
      if (rdy6) begin
         sig6_ff   <= sig6_in;
         empty6_ff <= empty5_ff;
      end
   end

   assign rsp_valid       = v6_ff;
   assign rsp_signature   = sig6_ff;
   assign rsp_empty_board = empty6_ff;

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 8x8 bitboard dihedral canonical form block.
// A queue of boards (a short directed list, then random shapes and noise)
// feeds a falling-edge driver that sends in bursts. A rising-edge monitor
// predicts the signature of every accepted word and compares each response
// word with the oldest prediction. The response side stalls on its own
// changing pattern, with two long hold-offs that fill the pipeline.
// ---------------------------------------------------------------------------
module tb_top;

   typedef bdcf_pkg::word_type word_type;

   localparam int unsigned RandomBoards = 2000;
   // Generous bound on the whole run.
   localparam int unsigned CycleLimit   = 200000;
   // The block is six stages deep, so this tail lets any stray word show.
   localparam int unsigned TailCycles   = 16;
   localparam int unsigned HoldCycles   = 100;
   localparam word_type    ColumnZero   = 64'h0101010101010101;

   // One predicted response word.
   typedef struct packed {
      word_type signature;
      logic     empty_board;
   } board_result_type;

   // How the receiver behaves within one stretch of its pattern.
   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_TOGGLE
   } stall_mode_type;

   // Families of random boards.
   typedef enum logic [2:0] {
      KIND_PATCH,
      KIND_SPARSE,
      KIND_FULL,
      KIND_DENSE,
      KIND_EDGE
   } board_kind_type;

   logic     clock           = 1'b0;
   logic     reset           = 1'b1;
   logic     req_valid       = 1'b0;
   logic     req_stall;
   word_type req_board       = '0;
   logic     rsp_valid;
   logic     rsp_stall       = 1'b0;
   word_type rsp_signature;
   logic     rsp_empty_board;

   word_type         pending_boards[$];
   board_result_type expected_results[$];
   int unsigned      board_total     = 0;
   int unsigned      boards_accepted = 0;
   int unsigned      mismatch_count  = 0;
   logic             req_taken       = 1'b0;

   bitboard_dihedral_canonical_form i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_board       (req_board),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_signature   (rsp_signature),
      .rsp_empty_board (rsp_empty_board)
   );

   always #5 clock = ~clock;

   // -------------------------------------------------------------------------
   // Prediction. Each helper is one of the board symmetries, written with
   // whole-word bit tricks rather than as a cell-by-cell copy where it can be.
   // -------------------------------------------------------------------------

   // Row r goes to row 7-r: a byte swap of the whole word.
   function automatic word_type mirror_rows(input word_type b);
      word_type r;
      r = '0;
      for (int i = 0; i < 8; i++) begin
         r[8*(7-i) +: 8] = b[8*i +: 8];
      end
      return r;
   endfunction

   // Column c goes to column 7-c: nibble, pair and bit swaps in every byte.
   function automatic word_type mirror_cols(input word_type b);
      word_type r;
      r = ((b & 64'hf0f0f0f0f0f0f0f0) >> 4) | ((b & 64'h0f0f0f0f0f0f0f0f) << 4);
      r = ((r & 64'hcccccccccccccccc) >> 2) | ((r & 64'h3333333333333333) << 2);
      r = ((r & 64'haaaaaaaaaaaaaaaa) >> 1) | ((r & 64'h5555555555555555) << 1);
      return r;
   endfunction

   // Reflection in the main diagonal: cell (row, col) moves to (col, row).
   function automatic word_type swap_axes(input word_type b);
      word_type r;
      r = '0;
      for (int row = 0; row < 8; row++) begin
         for (int col = 0; col < 8; col++) begin
            if (b[row*8 + col]) begin
               r[col*8 + row] = 1'b1;
            end
         end
      end
      return r;
   endfunction

   // Slide a nonzero image down to its lowest occupied row, then across to
   // its lowest occupied column.
   function automatic word_type slide_to_corner(input word_type b);
      word_type r;
      r = b;
      for (int k = 0; k < 7 && r[7:0] == 8'h00; k++) begin
         r = r >> 8;
      end
      for (int k = 0; k < 7 && (r & ColumnZero) == '0; k++) begin
         r = r >> 1;
      end
      return r;
   endfunction

   // Smallest normalised image over the eight symmetries of the square.
   function automatic board_result_type canonical_signature(input word_type b);
      board_result_type res;
      word_type         t;
      word_type         best;
      word_type         slid;
      word_type         images [8];
      if (b == '0) begin
         res.signature   = '0;
         res.empty_board = 1'b1;
         return res;
      end
      t         = swap_axes(b);
      images[0] = b;
      images[1] = mirror_rows(b);
      images[2] = mirror_cols(b);
      images[3] = mirror_rows(mirror_cols(b));
      images[4] = t;
      images[5] = mirror_rows(t);
      images[6] = mirror_cols(t);
      images[7] = mirror_rows(mirror_cols(t));
      best = '1;
      for (int i = 0; i < 8; i++) begin
         slid = slide_to_corner(images[i]);
         if (slid < best) begin
            best = slid;
         end
      end
      res.signature   = best;
      res.empty_board = 1'b0;
      return res;
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus. The whole list of boards is built at time zero, before reset
   // is released, so the driver never finds the queue still being filled.
   // -------------------------------------------------------------------------
   initial begin
      word_type       board;
      board_kind_type kind;
      int unsigned    pick;
      int unsigned    rows_h;
      int unsigned    cols_w;
      int unsigned    row0;
      int unsigned    col0;
      int unsigned    cells;

      // Directed boards: the empty board, the full board, lone corner cells,
      // edge rows and columns, both diagonals, checkerboards, and a few small
      // pieces that appear in different orientations and positions.
      pending_boards.push_back(64'h0000000000000000);
      pending_boards.push_back(64'hffffffffffffffff);
      pending_boards.push_back(64'h0000000000000001);
      pending_boards.push_back(64'h8000000000000000);
      pending_boards.push_back(64'h0000000000000080);
      pending_boards.push_back(64'h0100000000000000);
      pending_boards.push_back(64'h8000000000000001);
      pending_boards.push_back(64'h00000000000000ff);
      pending_boards.push_back(64'hff00000000000000);
      pending_boards.push_back(64'h0101010101010101);
      pending_boards.push_back(64'h8080808080808080);
      pending_boards.push_back(64'h8040201008040201);
      pending_boards.push_back(64'h0102040810204080);
      pending_boards.push_back(64'haa55aa55aa55aa55);
      pending_boards.push_back(64'h55aa55aa55aa55aa);
      pending_boards.push_back(64'hff00ff00ff00ff00);
      pending_boards.push_back(64'h00000000ffffffff);
      pending_boards.push_back(64'h0000000001010103);
      pending_boards.push_back(64'he080000000000000);
      pending_boards.push_back(64'h0000001000000000);
      pending_boards.push_back(64'hc0c0000000000000);
      pending_boards.push_back(64'h0000000000000207);
      pending_boards.push_back(64'h0000e04000000000);

      // Random boards. Small pieces dropped at random offsets dominate, since
      // they are what the block exists for; the rest is sparse noise, full
      // random words, nearly full boards and the odd empty or lone cell.
      for (int n = 0; n < RandomBoards; n++) begin
         pick = $urandom_range(0, 9);
         kind = pick < 4 ? KIND_PATCH :
                pick < 6 ? KIND_SPARSE :
                pick < 8 ? KIND_FULL :
                pick < 9 ? KIND_DENSE : KIND_EDGE;
         board = '0;
         case (kind)
            KIND_PATCH: begin
               rows_h = $urandom_range(1, 4);
               cols_w = $urandom_range(1, 4);
               row0   = $urandom_range(0, 8 - rows_h);
               col0   = $urandom_range(0, 8 - cols_w);
               for (int r = 0; r < rows_h; r++) begin
                  for (int c = 0; c < cols_w; c++) begin
                     if ($urandom_range(0, 1) == 1) begin
                        board[(row0 + r)*8 + col0 + c] = 1'b1;
                     end
                  end
               end
            end
            KIND_SPARSE: begin
               cells = $urandom_range(1, 6);
               for (int k = 0; k < cells; k++) begin
                  board[$urandom_range(0, 63)] = 1'b1;
               end
            end
            KIND_FULL: begin
               board = {$urandom(), $urandom()};
            end
            KIND_DENSE: begin
               board = '1;
               cells = $urandom_range(1, 6);
               for (int k = 0; k < cells; k++) begin
                  board[$urandom_range(0, 63)] = 1'b0;
               end
            end
            default: begin
               if ($urandom_range(0, 3) != 0) begin
                  board[$urandom_range(0, 63)] = 1'b1;
               end
            end
         endcase
         pending_boards.push_back(board);
      end
      board_total = pending_boards.size();
   end

   // -------------------------------------------------------------------------
   // Reset, completion and timeout. The completion test runs on the falling
   // edge, when the monitor's counters and queue are settled for the cycle.
   // -------------------------------------------------------------------------
   initial begin
      int unsigned cycle_count;
      logic        timed_out;
      cycle_count = 0;
      timed_out   = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (!(board_total != 0 && boards_accepted == board_total &&
               expected_results.size() == 0) && !timed_out) begin
         @(negedge clock);
         cycle_count++;
         if (cycle_count >= CycleLimit) begin
            timed_out = 1'b1;
         end
      end
      if (timed_out) begin
         $display("%0t: timeout, %0d of %0d boards accepted, %0d responses owed",
                  $time, boards_accepted, board_total, expected_results.size());
         $display("end of test: mismatches");
      end else begin
         // Any response word arriving in this tail has nothing waiting for
         // it, and the monitor counts it as a mismatch.
         repeat (TailCycles) @(negedge clock);
         if (mismatch_count == 0) begin
            $display("end of test: clean");
         end else begin
            $display("end of test: mismatches");
         end
      end
      $finish;
   end

   // -------------------------------------------------------------------------
   // Driver. It works on the falling edge. A new word is put up only when the
   // lane is empty or the word on it was taken at the last rising edge, so a
   // stalled word holds still and valid never looks at the stall.
   // -------------------------------------------------------------------------
   int unsigned burst_left = 1;
   int unsigned gap_left   = 0;

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left > 0) begin
            req_valid <= 1'b0;
            gap_left--;
         end else if (pending_boards.size() > 0) begin
            req_board <= pending_boards.pop_front();
            req_valid <= 1'b1;
            burst_left--;
            if (burst_left == 0) begin
               // Zero gaps are common, so long back-to-back streams occur.
               burst_left = $urandom_range(1, 40);
               gap_left   = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Receiver stall pattern. Stretches of random length each pick a mode:
   // free running, light or heavy random stalls, or a strict alternation.
   // Twice in the run the receiver holds off for a long count of cycles
   // while the sender keeps offering, so the stages fill and req_stall must
   // rise without any word being lost or repeated.
   // -------------------------------------------------------------------------
   int unsigned    stall_cycle  = 0;
   int unsigned    hold_left    = 0;
   int unsigned    segment_left = 0;
   stall_mode_type stall_mode   = STALL_NONE;

   always @(negedge clock) begin
      stall_cycle++;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (stall_cycle == 300 || stall_cycle == 2500) begin
         rsp_stall <= 1'b1;
         hold_left = HoldCycles - 1;
      end else begin
         if (segment_left == 0) begin
            stall_mode   = stall_mode_type'($urandom_range(0, 3));
            segment_left = $urandom_range(10, 150);
         end
         segment_left--;
         case (stall_mode)
            STALL_NONE:   rsp_stall <= 1'b0;
            STALL_LIGHT:  rsp_stall <= $urandom_range(0, 3) == 0;
            STALL_HEAVY:  rsp_stall <= $urandom_range(0, 3) != 0;
            default:      rsp_stall <= ~rsp_stall;
         endcase
      end
   end

   // -------------------------------------------------------------------------
   // Monitor. On each rising edge it records whether the request word was
   // taken, predicts the response for a taken board, and checks any response
   // word taken at the same edge against the oldest prediction.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      board_result_type want;
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_results.push_back(canonical_signature(req_board));
            boards_accepted++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $display("%0t: response word with nothing expected, signature %h",
                        $time, rsp_signature);
               mismatch_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_signature !== want.signature) begin
                  $display("%0t: signature expected %h, actual %h",
                           $time, want.signature, rsp_signature);
                  mismatch_count++;
               end
               if (rsp_empty_board !== want.empty_board) begin
                  $display("%0t: empty_board expected %b, actual %b",
                           $time, want.empty_board, rsp_empty_board);
                  mismatch_count++;
               end
            end
         end
      end
   end

endmodule
